[design/c8ie_pkg.sv]
// Shared types and opcode constants of the CHIP-8 execute unit.
`default_nettype none

package c8ie_pkg;

    // Request kinds carried in tuser
    localparam logic [1:0] OP_EXEC     = 2'd0;
    localparam logic [1:0] OP_WRITE    = 2'd1;
    localparam logic [1:0] OP_READ_ROW = 2'd2;

    // Top nibble of the instruction word
    localparam logic [3:0] OPC_SYS     = 4'h0;
    localparam logic [3:0] OPC_JP      = 4'h1;
    localparam logic [3:0] OPC_CALL    = 4'h2;
    localparam logic [3:0] OPC_SE_IMM  = 4'h3;
    localparam logic [3:0] OPC_SNE_IMM = 4'h4;
    localparam logic [3:0] OPC_SE_REG  = 4'h5;
    localparam logic [3:0] OPC_LD_IMM  = 4'h6;
    localparam logic [3:0] OPC_ADD_IMM = 4'h7;
    localparam logic [3:0] OPC_ALU     = 4'h8;
    localparam logic [3:0] OPC_SNE_REG = 4'h9;
    localparam logic [3:0] OPC_LD_I    = 4'hA;
    localparam logic [3:0] OPC_JP_V0   = 4'hB;
    localparam logic [3:0] OPC_RND     = 4'hC;
    localparam logic [3:0] OPC_DRW     = 4'hD;
    localparam logic [3:0] OPC_KEY     = 4'hE;
    localparam logic [3:0] OPC_MISC    = 4'hF;

    localparam logic [15:0] INS_CLS = 16'h00E0;
    localparam logic [15:0] INS_RET = 16'h00EE;

    // Low nibble of 8xyn
    localparam logic [3:0] ALU_LD   = 4'h0;
    localparam logic [3:0] ALU_OR   = 4'h1;
    localparam logic [3:0] ALU_AND  = 4'h2;
    localparam logic [3:0] ALU_XOR  = 4'h3;
    localparam logic [3:0] ALU_ADD  = 4'h4;
    localparam logic [3:0] ALU_SUB  = 4'h5;
    localparam logic [3:0] ALU_SHR  = 4'h6;
    localparam logic [3:0] ALU_SUBN = 4'h7;
    localparam logic [3:0] ALU_SHL  = 4'hE;

    // Low byte of Ex and Fx forms
    localparam logic [7:0] KEY_SKP     = 8'h9E;
    localparam logic [7:0] KEY_SKNP    = 8'hA1;
    localparam logic [7:0] MISC_LD_DT  = 8'h07;
    localparam logic [7:0] MISC_WAIT   = 8'h0A;
    localparam logic [7:0] MISC_SET_DT = 8'h15;
    localparam logic [7:0] MISC_SET_ST = 8'h18;
    localparam logic [7:0] MISC_ADD_I  = 8'h1E;
    localparam logic [7:0] MISC_FONT   = 8'h29;
    localparam logic [7:0] MISC_STORE  = 8'h55;
    localparam logic [7:0] MISC_LOAD   = 8'h65;

    localparam logic [3:0]  REG_VF  = 4'hF;
    localparam logic [11:0] PC_STEP = 12'd2;
    localparam logic [11:0] PC_SKIP = 12'd4;

    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 120;
    localparam int ROW_W      = 64;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_EXEC,
        S_WB,
        S_REDUCE,
        S_DRAW_RD,
        S_DRAW_WR,
        S_MOVE_RD,
        S_MOVE_WR,
        S_ROW,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        K_SIMPLE,
        K_DRAW,
        K_STORE,
        K_LOAD,
        K_ROW
    } t_kind;

    typedef struct packed {
        logic       capture;
        logic       rd_regs;
        logic       exec;
        logic       wb;
        logic       reduce;
        logic       draw_rd;
        logic       draw_wr;
        logic       move_rd;
        logic       move_wr;
        logic       row_rd;
        logic       load_out;
        logic [3:0] cnt;
    } t_cmd;

    typedef struct packed {
        t_kind      kind;
        logic [3:0] n;
        logic [3:0] x;
        logic       reduce_done;
    } t_status;

endpackage

`default_nettype wire

[design/c8ie_ctrl.sv]
// Controller state machine of the CHIP-8 execute unit.
`default_nettype none

module c8ie_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_s_valid,
    output logic             o_s_ready,
    output logic             o_m_valid,
    input  wire              i_m_ready,
    input  c8ie_pkg::t_status i_status,
    output c8ie_pkg::t_cmd   o_cmd
);

    c8ie_pkg::t_state r_state, n_state;
    logic [3:0]       r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= c8ie_pkg::S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_m_ready;
        o_cmd       = '0;
        o_cmd.cnt   = r_cnt;
        o_s_ready   = 1'b0;
        unique case (r_state)
            c8ie_pkg::S_IDLE: begin
                o_s_ready = 1'b1;
                if (i_s_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = c8ie_pkg::S_READ;
                end
            end
            c8ie_pkg::S_READ: begin
                o_cmd.rd_regs = 1'b1;
                n_state       = c8ie_pkg::S_EXEC;
            end
            c8ie_pkg::S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_cnt      = '0;
                unique case (i_status.kind)
                    c8ie_pkg::K_DRAW:                  n_state = c8ie_pkg::S_REDUCE;
                    c8ie_pkg::K_STORE, c8ie_pkg::K_LOAD: n_state = c8ie_pkg::S_MOVE_RD;
                    c8ie_pkg::K_ROW:                   n_state = c8ie_pkg::S_ROW;
                    default:                           n_state = c8ie_pkg::S_WB;
                endcase
            end
            c8ie_pkg::S_WB: begin
                o_cmd.wb = 1'b1;
                n_state  = c8ie_pkg::S_DONE;
            end
            c8ie_pkg::S_REDUCE: begin
                o_cmd.reduce = 1'b1;
                if (i_status.reduce_done) begin
                    n_state = c8ie_pkg::S_DRAW_RD;
                end
            end
            c8ie_pkg::S_DRAW_RD: begin
                o_cmd.draw_rd = 1'b1;
                n_state       = c8ie_pkg::S_DRAW_WR;
            end
            c8ie_pkg::S_DRAW_WR: begin
                o_cmd.draw_wr = 1'b1;
                if (r_cnt == i_status.n - 4'd1) begin
                    n_state = c8ie_pkg::S_DONE;
                end else begin
                    n_cnt   = r_cnt + 4'd1;
                    n_state = c8ie_pkg::S_DRAW_RD;
                end
            end
            c8ie_pkg::S_MOVE_RD: begin
                o_cmd.move_rd = 1'b1;
                n_state       = c8ie_pkg::S_MOVE_WR;
            end
            c8ie_pkg::S_MOVE_WR: begin
                o_cmd.move_wr = 1'b1;
                if (r_cnt == i_status.x) begin
                    n_state = c8ie_pkg::S_DONE;
                end else begin
                    n_cnt   = r_cnt + 4'd1;
                    n_state = c8ie_pkg::S_MOVE_RD;
                end
            end
            c8ie_pkg::S_ROW: begin
                o_cmd.row_rd = 1'b1;
                n_state      = c8ie_pkg::S_DONE;
            end
            c8ie_pkg::S_DONE: begin
                // hold until the output register is free
                if (!r_out_valid || i_m_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = c8ie_pkg::S_IDLE;
                end
            end
            default: n_state = c8ie_pkg::S_IDLE;
        endcase
    end

    assign o_m_valid = r_out_valid;

endmodule

`default_nettype wire

[design/c8ie_datapath.sv]
// Datapath of the CHIP-8 execute unit: registers, stack, RAM, screen and ALU.
`default_nettype none

module c8ie_datapath #(
    parameter int MEMORY_DEPTH  = 4096,
    parameter int SCREEN_WIDTH  = 64,
    parameter int SCREEN_HEIGHT = 32,
    parameter int STACK_DEPTH   = 16
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_cfg_wr_en,
    input  wire  [11:0]                          i_cfg_wr_data,
    input  wire  [c8ie_pkg::IN_DATA_W-1:0]       i_s_tdata,
    input  wire  [1:0]                           i_s_tuser,
    input  c8ie_pkg::t_cmd                       i_cmd,
    output c8ie_pkg::t_status                    o_status,
    output logic [c8ie_pkg::OUT_DATA_W-1:0]      o_m_tdata
);

    localparam int AW  = $clog2(MEMORY_DEPTH);
    localparam int CW  = $clog2(SCREEN_WIDTH);
    localparam int HW  = $clog2(SCREEN_HEIGHT);
    localparam int SPW = $clog2(STACK_DEPTH);

    function automatic logic [AW-1:0] f_wrap(input logic [12:0] a);
        logic [15:0] t;
        t = 16'(a);
        for (int k = 3; k >= 0; k--) begin
            if (t >= 16'(MEMORY_DEPTH << k)) t = t - 16'(MEMORY_DEPTH << k);
        end
        return t[AW-1:0];
    endfunction

    // captured request
    logic [1:0]  r_op;
    logic [15:0] r_ins;
    logic [11:0] r_addr;
    logic [7:0]  r_data, r_rnd;
    logic        r_kp;
    logic [3:0]  r_kc;

    // architectural state
    logic [11:0]    r_pc, r_i, r_base, r_font;
    logic [SPW-1:0] r_sp;
    logic [7:0]     r_dt, r_st, r_vf;
    logic           r_wait;

    logic [7:0]  r_rf [16];
    logic [15:0] r_rf_val;
    logic [7:0]  r_qa, r_qb;
    logic        r_qa_v, r_qb_v;
    logic        r_wb_en;
    logic [7:0]  r_wb_val;

    logic [11:0] r_stack [STACK_DEPTH];
    logic [7:0]  r_ram [MEMORY_DEPTH];
    logic [7:0]  r_ram_q;

    logic [SCREEN_WIDTH-1:0]  r_fb [SCREEN_HEIGHT];
    logic [SCREEN_HEIGHT-1:0] r_fb_val;
    logic [SCREEN_WIDTH-1:0]  r_fb_q, r_row_out;
    logic                     r_fb_qv;
    logic [7:0]               r_colr, r_rowr;
    logic [c8ie_pkg::OUT_DATA_W-1:0] r_out;

    logic [3:0]  top, x, y, n;
    logic [7:0]  kk, va, vb;
    logic [11:0] nnn;
    c8ie_pkg::t_kind kind;

    assign top = r_ins[15:12];
    assign x   = r_ins[11:8];
    assign y   = r_ins[7:4];
    assign n   = r_ins[3:0];
    assign kk  = r_ins[7:0];
    assign nnn = r_ins[11:0];
    assign va  = r_qa_v ? r_qa : 8'd0;
    assign vb  = r_qb_v ? r_qb : 8'd0;

    always_comb begin
        kind = c8ie_pkg::K_SIMPLE;
        if (r_op == c8ie_pkg::OP_READ_ROW) begin
            kind = c8ie_pkg::K_ROW;
        end else if (r_op == c8ie_pkg::OP_EXEC) begin
            if (top == c8ie_pkg::OPC_DRW && n != 4'd0) kind = c8ie_pkg::K_DRAW;
            else if (top == c8ie_pkg::OPC_MISC && kk == c8ie_pkg::MISC_STORE)
                kind = c8ie_pkg::K_STORE;
            else if (top == c8ie_pkg::OPC_MISC && kk == c8ie_pkg::MISC_LOAD)
                kind = c8ie_pkg::K_LOAD;
        end
    end

    assign o_status.kind        = kind;
    assign o_status.n           = n;
    assign o_status.x           = x;
    assign o_status.reduce_done = (r_colr < 8'(SCREEN_WIDTH)) && (r_rowr < 8'(SCREEN_HEIGHT));

    // instruction execute
    logic [11:0]    n_pc, n_i;
    logic [SPW-1:0] n_sp, sp_inc, sp_dec;
    logic [7:0]     n_dt, n_st, n_wb_val, e_fw_val;
    logic           n_wait, n_wb_en, e_fw_en, stk_we, fb_clear, key_match;
    logic [8:0]     sum9;

    always_comb begin
        sp_inc    = (r_sp == SPW'(STACK_DEPTH - 1)) ? '0 : r_sp + 1'b1;
        sp_dec    = (r_sp == '0) ? SPW'(STACK_DEPTH - 1) : r_sp - 1'b1;
        key_match = r_kp && ({4'd0, r_kc} == va);
        sum9      = {1'b0, va} + {1'b0, vb};
        n_pc      = r_pc + c8ie_pkg::PC_STEP;
        n_i       = r_i;
        n_sp      = r_sp;
        n_dt      = r_dt;
        n_st      = r_st;
        n_wait    = 1'b0;
        n_wb_en   = 1'b0;
        n_wb_val  = 8'd0;
        e_fw_en   = 1'b0;
        e_fw_val  = 8'd0;
        stk_we    = 1'b0;
        fb_clear  = 1'b0;
        if (r_op != c8ie_pkg::OP_EXEC) begin
            n_pc = r_pc;
        end else begin
            unique case (top)
                c8ie_pkg::OPC_SYS: begin
                    if (r_ins == c8ie_pkg::INS_CLS) begin
                        fb_clear = 1'b1;
                    end else if (r_ins == c8ie_pkg::INS_RET) begin
                        n_pc = r_stack[r_sp];
                        n_sp = sp_dec;
                    end
                end
                c8ie_pkg::OPC_JP: n_pc = nnn;
                c8ie_pkg::OPC_CALL: begin
                    n_sp   = sp_inc;
                    stk_we = 1'b1;
                    n_pc   = nnn;
                end
                c8ie_pkg::OPC_SE_IMM:
                    if (va == kk) n_pc = r_pc + c8ie_pkg::PC_SKIP;
                c8ie_pkg::OPC_SNE_IMM:
                    if (va != kk) n_pc = r_pc + c8ie_pkg::PC_SKIP;
                c8ie_pkg::OPC_SE_REG:
                    if (n == 4'd0 && va == vb) n_pc = r_pc + c8ie_pkg::PC_SKIP;
                c8ie_pkg::OPC_LD_IMM: begin
                    n_wb_en  = 1'b1;
                    n_wb_val = kk;
                end
                c8ie_pkg::OPC_ADD_IMM: begin
                    n_wb_en  = 1'b1;
                    n_wb_val = va + kk;
                end
                c8ie_pkg::OPC_ALU: begin
                    n_wb_en = 1'b1;
                    case (n)
                        c8ie_pkg::ALU_LD:  n_wb_val = vb;
                        c8ie_pkg::ALU_OR:  n_wb_val = va | vb;
                        c8ie_pkg::ALU_AND: n_wb_val = va & vb;
                        c8ie_pkg::ALU_XOR: n_wb_val = va ^ vb;
                        c8ie_pkg::ALU_ADD: begin
                            e_fw_en  = 1'b1;
                            e_fw_val = {7'd0, sum9[8]};
                            n_wb_val = sum9[7:0];
                        end
                        c8ie_pkg::ALU_SUB: begin
                            e_fw_en  = 1'b1;
                            e_fw_val = {7'd0, va > vb};
                            n_wb_val = va - vb;
                        end
                        c8ie_pkg::ALU_SHR: begin
                            e_fw_en  = 1'b1;
                            e_fw_val = {7'd0, va[0]};
                            n_wb_val = {1'b0, va[7:1]};
                        end
                        c8ie_pkg::ALU_SUBN: begin
                            e_fw_en  = 1'b1;
                            e_fw_val = {7'd0, vb > va};
                            n_wb_val = vb - va;
                        end
                        c8ie_pkg::ALU_SHL: begin
                            e_fw_en  = 1'b1;
                            e_fw_val = {7'd0, va[7]};
                            n_wb_val = {va[6:0], 1'b0};
                        end
                        default: n_wb_en = 1'b0;
                    endcase
                end
                c8ie_pkg::OPC_SNE_REG:
                    if (n == 4'd0 && va != vb) n_pc = r_pc + c8ie_pkg::PC_SKIP;
                c8ie_pkg::OPC_LD_I: n_i = nnn;
                c8ie_pkg::OPC_JP_V0: n_pc = nnn + {4'd0, vb};
                c8ie_pkg::OPC_RND: begin
                    n_wb_en  = 1'b1;
                    n_wb_val = r_rnd & kk;
                end
                c8ie_pkg::OPC_DRW: begin
                    // clear VF before the sprite rows
                    e_fw_en = 1'b1;
                end
                c8ie_pkg::OPC_KEY: begin
                    if ((kk == c8ie_pkg::KEY_SKP && key_match) ||
                        (kk == c8ie_pkg::KEY_SKNP && !key_match))
                        n_pc = r_pc + c8ie_pkg::PC_SKIP;
                end
                default: begin
                    case (kk)
                        c8ie_pkg::MISC_LD_DT: begin
                            n_wb_en  = 1'b1;
                            n_wb_val = r_dt;
                        end
                        c8ie_pkg::MISC_WAIT: begin
                            if (!r_kp) begin
                                n_wait = 1'b1;
                                n_pc   = r_pc;
                            end else begin
                                n_wb_en  = 1'b1;
                                n_wb_val = {4'd0, r_kc};
                            end
                        end
                        c8ie_pkg::MISC_SET_DT: n_dt = va;
                        c8ie_pkg::MISC_SET_ST: n_st = va;
                        c8ie_pkg::MISC_ADD_I:  n_i  = r_i + {4'd0, va};
                        c8ie_pkg::MISC_FONT:
                            n_i = r_font + {6'd0, va[3:0], 2'd0} + {8'd0, va[3:0]};
                        c8ie_pkg::MISC_STORE, c8ie_pkg::MISC_LOAD:
                            n_i = r_i + {8'd0, x} + 12'd1;
                        default: n_i = r_i;
                    endcase
                end
            endcase
        end
    end

    // sprite row combine
    logic [SCREEN_WIDTH-1:0] fb_row, mask;
    logic [7:0]              cb;
    logic                    hit;

    always_comb begin
        fb_row = r_fb_qv ? r_fb_q : '0;
        mask   = '0;
        cb     = 8'd0;
        for (int b = 0; b < 8; b++) begin
            cb = r_colr + 8'(b);
            if (cb >= 8'(SCREEN_WIDTH)) cb = cb - 8'(SCREEN_WIDTH);
            if (r_ram_q[7-b]) mask[cb[CW-1:0]] = 1'b1;
        end
        hit = |(fb_row & mask);
    end

    // register file write and read ports
    logic       rf_we;
    logic [3:0] rf_wa, ra_a, ra_b;
    logic [7:0] rf_wd;

    always_comb begin
        rf_we = 1'b0;
        rf_wa = x;
        rf_wd = r_wb_val;
        if (i_cmd.exec && e_fw_en) begin
            rf_we = 1'b1;
            rf_wa = c8ie_pkg::REG_VF;
            rf_wd = e_fw_val;
        end else if (i_cmd.wb && r_wb_en) begin
            rf_we = 1'b1;
        end else if (i_cmd.draw_wr && hit) begin
            rf_we = 1'b1;
            rf_wa = c8ie_pkg::REG_VF;
            rf_wd = 8'd1;
        end else if (i_cmd.move_wr && kind == c8ie_pkg::K_LOAD) begin
            rf_we = 1'b1;
            rf_wa = i_cmd.cnt;
            rf_wd = r_ram_q;
        end
        ra_a = i_cmd.move_rd ? i_cmd.cnt : x;
        ra_b = (top == c8ie_pkg::OPC_JP_V0) ? 4'd0 : y;
    end

    always_ff @(posedge i_clk) begin
        if (rf_we) r_rf[rf_wa] <= rf_wd;
        if (i_cmd.rd_regs || i_cmd.move_rd) begin
            r_qa   <= r_rf[ra_a];
            r_qa_v <= r_rf_val[ra_a];
            r_qb   <= r_rf[ra_b];
            r_qb_v <= r_rf_val[ra_b];
        end
    end

    // RAM port
    logic          ram_we;
    logic [AW-1:0] ram_a;
    logic [7:0]    ram_wd;

    always_comb begin
        ram_we = 1'b0;
        ram_wd = r_data;
        ram_a  = f_wrap({1'b0, r_addr});
        if (i_cmd.exec && r_op == c8ie_pkg::OP_WRITE) begin
            ram_we = 1'b1;
        end else if (i_cmd.draw_rd) begin
            ram_a = f_wrap({1'b0, r_i} + {9'd0, i_cmd.cnt});
        end else if (i_cmd.move_rd || i_cmd.move_wr) begin
            ram_a  = f_wrap({1'b0, r_base} + {9'd0, i_cmd.cnt});
            ram_we = i_cmd.move_wr && kind == c8ie_pkg::K_STORE;
            ram_wd = va;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ram_we) r_ram[ram_a] <= ram_wd;
        r_ram_q <= r_ram[ram_a];
    end

    // frame store
    logic [HW-1:0] fb_a;
    assign fb_a = i_cmd.draw_rd ? r_rowr[HW-1:0] : r_addr[HW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.draw_wr) r_fb[r_rowr[HW-1:0]] <= fb_row ^ mask;
        if (i_cmd.draw_rd || i_cmd.exec) begin
            r_fb_q  <= r_fb[fb_a];
            r_fb_qv <= r_fb_val[fb_a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && stk_we) r_stack[sp_inc] <= r_pc + c8ie_pkg::PC_STEP;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc     <= 12'h200;
            r_i      <= '0;
            r_sp     <= '0;
            r_dt     <= '0;
            r_st     <= '0;
            r_vf     <= '0;
            r_wait   <= 1'b0;
            r_font   <= '0;
            r_rf_val <= '0;
            r_fb_val <= '0;
        end else begin
            if (i_cfg_wr_en) r_font <= i_cfg_wr_data;
            if (i_cmd.capture) r_wait <= 1'b0;
            if (i_cmd.exec) begin
                r_pc   <= n_pc;
                r_i    <= n_i;
                r_sp   <= n_sp;
                r_dt   <= n_dt;
                r_st   <= n_st;
                r_wait <= n_wait;
            end
            if (rf_we) begin
                r_rf_val[rf_wa] <= 1'b1;
                if (rf_wa == c8ie_pkg::REG_VF) r_vf <= rf_wd;
            end
            if (i_cmd.exec && fb_clear) r_fb_val <= '0;
            else if (i_cmd.draw_wr) r_fb_val[r_rowr[HW-1:0]] <= 1'b1;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_ins     <= i_s_tdata[15:0];
            r_addr    <= i_s_tdata[27:16];
            r_data    <= i_s_tdata[35:28];
            r_kp      <= i_s_tdata[36];
            r_kc      <= i_s_tdata[40:37];
            r_rnd     <= i_s_tdata[48:41];
            r_op      <= i_s_tuser;
            r_row_out <= '0;
        end
        if (i_cmd.exec) begin
            r_wb_en  <= n_wb_en;
            r_wb_val <= n_wb_val;
            r_base   <= r_i;
            r_colr   <= va;
            r_rowr   <= vb;
        end
        if (i_cmd.reduce) begin
            if (r_colr >= 8'(SCREEN_WIDTH))  r_colr <= r_colr - 8'(SCREEN_WIDTH);
            if (r_rowr >= 8'(SCREEN_HEIGHT)) r_rowr <= r_rowr - 8'(SCREEN_HEIGHT);
        end
        if (i_cmd.draw_wr) begin
            r_rowr <= (r_rowr == 8'(SCREEN_HEIGHT - 1)) ? 8'd0 : r_rowr + 8'd1;
        end
        if (i_cmd.row_rd) begin
            r_row_out <= ({1'b0, r_addr[4:0]} < 6'(SCREEN_HEIGHT) && r_fb_qv) ? r_fb_q : '0;
        end
        if (i_cmd.load_out) begin
            r_out <= {7'd0, c8ie_pkg::ROW_W'(r_row_out), r_wait, r_st, r_dt, r_vf, r_i, r_pc};
        end
    end

    assign o_m_tdata = r_out;

endmodule

`default_nettype wire

[design/chip8_instruction_execute.sv]
// Top level of the CHIP-8 execute unit: controller plus datapath.
`default_nettype none

// Executes one CHIP-8 request at a time: tuser 0 runs the instruction word,
// 1 writes a RAM byte, 2 reads one screen row. Every request returns one
// result carrying PC, I, VF, both timers, the key-wait flag and, for a row
// read, the row pixels. Most requests pass from the accepting edge to the
// next accept through capture, register file read, execute, write back or
// row read, and output load. A sprite draw Dxyn with n > 0 instead runs a
// reduce step that subtracts the screen size from Vx and Vy until both lie
// in screen range (both reduce together: up to 7 subtraction steps at the
// default size, up to 31 for 8-pixel screens), then for each sprite row a
// RAM read followed by a frame row read-modify-write. Fx55/Fx65 move V0 to
// Vx one register at a time, a read then a write for each, over the
// single-port register file and RAM. A new request is taken once the previous
// one has reached the output register; the result waits there while the next
// request runs, and the output load of that next request holds while the
// earlier result is still unaccepted. The frame store clears through per-row
// valid bits, so reset and CLS need no sweep. RAM and the return stack hold
// no reset value.
module chip8_instruction_execute #(
    parameter int MEMORY_DEPTH  = 4096,
    parameter int SCREEN_WIDTH  = 64,
    parameter int SCREEN_HEIGHT = 32,
    parameter int STACK_DEPTH   = 16
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    // font_base register write
    input  wire                                  i_cfg_wr_en,
    input  wire  [11:0]                          i_cfg_wr_data,
    // request stream
    input  wire                                  s_axis_tvalid,
    output logic                                 s_axis_tready,
    // instruction[15:0], address[27:16], load_data[35:28], key_pressed[36],
    // key_code[40:37], random_byte[48:41], zero pad to 55
    input  wire  [c8ie_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // op[1:0]
    input  wire  [1:0]                           s_axis_tuser,
    // result stream
    output logic                                 m_axis_tvalid,
    input  wire                                  m_axis_tready,
    // program_counter[11:0], index_value[23:12], flag_value[31:24],
    // delay_value[39:32], sound_value[47:40], waiting_key[48],
    // screen_row[112:49], zero pad to 119
    output logic [c8ie_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);

    c8ie_pkg::t_cmd    cmd;
    c8ie_pkg::t_status status;

    // sequencing: one request in flight, output register decoupled
    c8ie_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .o_m_valid (m_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .i_status  (status),
        .o_cmd     (cmd)
    );

    // storage and arithmetic
    c8ie_datapath #(
        .MEMORY_DEPTH  (MEMORY_DEPTH),
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .STACK_DEPTH   (STACK_DEPTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_s_tdata     (s_axis_tdata),
        .i_s_tuser     (s_axis_tuser),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_m_tdata     (m_axis_tdata)
    );

endmodule

`default_nettype wire

[dv/chip8_instruction_execute_tb.sv]
// Self-checking testbench for the CHIP-8 execute unit over its request and result streams.
`timescale 1ns / 100ps

module chip8_instruction_execute_tb;

    // Codes only the testbench needs
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [7:0] MISC_BCD  = 8'h33;
    localparam logic [7:0] MISC_NONE = 8'h00;

    // One request as it travels on the slave side
    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] ins;
        logic [11:0] addr;
        logic [7:0]  data;
        logic        key_down;
        logic [3:0]  key;
        logic [7:0]  rnd;
    } t_req;

    // One machine snapshot as it comes back on the master side
    typedef struct packed {
        logic [11:0] pc;
        logic [11:0] idx;
        logic [7:0]  vf;
        logic [7:0]  dt;
        logic [7:0]  st;
        logic        waiting;
        logic [63:0] row;
    } t_snap;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_cfg_wr_en;
    logic [11:0]                     i_cfg_wr_data;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    logic [c8ie_pkg::IN_DATA_W-1:0]  s_axis_tdata;
    logic [1:0]                      s_axis_tuser;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    logic [c8ie_pkg::OUT_DATA_W-1:0] m_axis_tdata;

    chip8_instruction_execute dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Machine state as the testbench expects it to be
    logic [7:0]  vreg [16];
    logic [11:0] pc_m, idx_m, font_m;
    logic [11:0] call_stack [16];
    bit          call_ok [16];
    logic [3:0]  sp_m;
    logic [7:0]  dt_m, st_m;
    logic [7:0]  ram [4096];
    bit          ram_ok [4096];
    logic [63:0] frame [32];

    t_req  pending_requests [$];
    t_snap expected_snapshots [$];
    int    mismatches;
    bit    quiet;
    int    send_gap, recv_gap;

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // Hard stop in case the block hangs
    initial begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        mismatches++;
    endtask

    // Apply one request to the expected machine state and return the snapshot
    task automatic execute_request(input t_req r, output t_snap s);
        logic [3:0]  top, x, y, n;
        logic [7:0]  kk, va, vc, bits;
        logic [8:0]  sum;
        logic [11:0] a;
        int          adv, col, row;
        bit          hit;
        top = r.ins[15:12]; x = r.ins[11:8]; y = r.ins[7:4]; n = r.ins[3:0];
        kk = r.ins[7:0];
        adv = 2;
        s = '0;
        if (r.op == c8ie_pkg::OP_EXEC) begin
            hit = r.key_down && (r.key == vreg[x]);
            case (top)
                c8ie_pkg::OPC_SYS: begin
                    if (r.ins == c8ie_pkg::INS_CLS) begin
                        for (int i = 0; i < 32; i++) frame[i] = '0;
                    end else if (r.ins == c8ie_pkg::INS_RET) begin
                        pc_m = call_stack[sp_m];
                        sp_m = sp_m - 4'd1;
                        adv = -1;
                    end
                end
                c8ie_pkg::OPC_JP: begin
                    pc_m = r.ins[11:0]; adv = -1;
                end
                c8ie_pkg::OPC_CALL: begin
                    sp_m = sp_m + 4'd1;
                    call_stack[sp_m] = pc_m + c8ie_pkg::PC_STEP;
                    call_ok[sp_m] = 1'b1;
                    pc_m = r.ins[11:0]; adv = -1;
                end
                c8ie_pkg::OPC_SE_IMM:  adv = (vreg[x] == kk) ? 4 : 2;
                c8ie_pkg::OPC_SNE_IMM: adv = (vreg[x] != kk) ? 4 : 2;
                c8ie_pkg::OPC_SE_REG:  adv = (n == 4'd0 && vreg[x] == vreg[y]) ? 4 : 2;
                c8ie_pkg::OPC_SNE_REG: adv = (n == 4'd0 && vreg[x] != vreg[y]) ? 4 : 2;
                c8ie_pkg::OPC_LD_IMM:  vreg[x] = kk;
                c8ie_pkg::OPC_ADD_IMM: vreg[x] = vreg[x] + kk;
                c8ie_pkg::OPC_ALU: begin
                    va = vreg[x]; vc = vreg[y];
                    // VF goes first so that x = F keeps the arithmetic result
                    case (n)
                        c8ie_pkg::ALU_LD:  vreg[x] = vc;
                        c8ie_pkg::ALU_OR:  vreg[x] = va | vc;
                        c8ie_pkg::ALU_AND: vreg[x] = va & vc;
                        c8ie_pkg::ALU_XOR: vreg[x] = va ^ vc;
                        c8ie_pkg::ALU_ADD: begin
                            sum = {1'b0, va} + {1'b0, vc};
                            vreg[c8ie_pkg::REG_VF] = {7'd0, sum[8]};
                            vreg[x] = sum[7:0];
                        end
                        c8ie_pkg::ALU_SUB: begin
                            vreg[c8ie_pkg::REG_VF] = {7'd0, va > vc}; vreg[x] = va - vc;
                        end
                        c8ie_pkg::ALU_SHR: begin
                            vreg[c8ie_pkg::REG_VF] = {7'd0, va[0]}; vreg[x] = va >> 1;
                        end
                        c8ie_pkg::ALU_SUBN: begin
                            vreg[c8ie_pkg::REG_VF] = {7'd0, vc > va}; vreg[x] = vc - va;
                        end
                        c8ie_pkg::ALU_SHL: begin
                            vreg[c8ie_pkg::REG_VF] = {7'd0, va[7]}; vreg[x] = va << 1;
                        end
                        default: ;
                    endcase
                end
                c8ie_pkg::OPC_LD_I:  idx_m = r.ins[11:0];
                c8ie_pkg::OPC_JP_V0: begin
                    pc_m = r.ins[11:0] + {4'd0, vreg[0]}; adv = -1;
                end
                c8ie_pkg::OPC_RND:   vreg[x] = r.rnd & kk;
                c8ie_pkg::OPC_DRW: begin
                    // Clear VF, then XOR each sprite row in with wrap on both axes
                    row = vreg[y] % 32;
                    va = vreg[x];
                    vreg[c8ie_pkg::REG_VF] = 8'd0;
                    for (int k = 0; k < n; k++) begin
                        a = idx_m + k[11:0];
                        bits = ram[a];
                        col = va % 64;
                        for (int b = 0; b < 8; b++) begin
                            if (bits[7-b]) begin
                                if (frame[row][col]) vreg[c8ie_pkg::REG_VF] = 8'd1;
                                frame[row][col] = ~frame[row][col];
                            end
                            col = (col + 1) % 64;
                        end
                        row = (row + 1) % 32;
                    end
                end
                c8ie_pkg::OPC_KEY: begin
                    if (kk == c8ie_pkg::KEY_SKP) adv = hit ? 4 : 2;
                    else if (kk == c8ie_pkg::KEY_SKNP) adv = hit ? 2 : 4;
                end
                default: begin
                    case (kk)
                        c8ie_pkg::MISC_LD_DT:  vreg[x] = dt_m;
                        c8ie_pkg::MISC_WAIT: begin
                            if (!r.key_down) begin
                                s.waiting = 1'b1; adv = 0;
                            end else begin
                                vreg[x] = {4'd0, r.key};
                            end
                        end
                        c8ie_pkg::MISC_SET_DT: dt_m = vreg[x];
                        c8ie_pkg::MISC_SET_ST: st_m = vreg[x];
                        c8ie_pkg::MISC_ADD_I:  idx_m = idx_m + {4'd0, vreg[x]};
                        c8ie_pkg::MISC_FONT:
                            idx_m = font_m + 12'd5 * {8'd0, vreg[x][3:0]};
                        c8ie_pkg::MISC_STORE: begin
                            for (int i = 0; i <= x; i++) begin
                                a = idx_m + i[11:0];
                                ram[a] = vreg[i]; ram_ok[a] = 1'b1;
                            end
                            idx_m = idx_m + {8'd0, x} + 12'd1;
                        end
                        c8ie_pkg::MISC_LOAD: begin
                            for (int i = 0; i <= x; i++) begin
                                a = idx_m + i[11:0];
                                vreg[i] = ram[a];
                            end
                            idx_m = idx_m + {8'd0, x} + 12'd1;
                        end
                        default: ;
                    endcase
                end
            endcase
            if (adv >= 0) pc_m = pc_m + adv[11:0];
        end else if (r.op == c8ie_pkg::OP_WRITE) begin
            ram[r.addr] = r.data; ram_ok[r.addr] = 1'b1;
        end else if (r.op == c8ie_pkg::OP_READ_ROW) begin
            s.row = frame[r.addr[4:0]];
        end
        s.pc = pc_m; s.idx = idx_m; s.vf = vreg[c8ie_pkg::REG_VF]; s.dt = dt_m; s.st = st_m;
    endtask

    // True when the request reads no RAM byte or stack entry that was never written
    function automatic bit reads_defined(input t_req r);
        logic [11:0] a;
        if (r.op != c8ie_pkg::OP_EXEC) return 1;
        if (r.ins == c8ie_pkg::INS_RET) return call_ok[sp_m];
        if (r.ins[15:12] == c8ie_pkg::OPC_DRW) begin
            for (int k = 0; k < r.ins[3:0]; k++) begin
                a = idx_m + k[11:0];
                if (!ram_ok[a]) return 0;
            end
        end
        if (r.ins[15:12] == c8ie_pkg::OPC_MISC && r.ins[7:0] == c8ie_pkg::MISC_LOAD) begin
            for (int i = 0; i <= r.ins[11:8]; i++) begin
                a = idx_m + i[11:0];
                if (!ram_ok[a]) return 0;
            end
        end
        return 1;
    endfunction

    task automatic queue_request(input t_req r);
        t_snap s;
        execute_request(r, s);
        pending_requests.push_back(r);
        expected_snapshots.push_back(s);
    endtask

    task automatic queue_exec(input logic [15:0] ins, input logic key_down,
                              input logic [3:0] key);
        t_req r;
        r = '{op: c8ie_pkg::OP_EXEC, ins: ins, addr: 12'($urandom), data: 8'($urandom),
              key_down: key_down, key: key, rnd: 8'($urandom)};
        queue_request(r);
    endtask

    task automatic queue_write(input logic [11:0] addr, input logic [7:0] data);
        t_req r;
        r = '{op: c8ie_pkg::OP_WRITE, ins: 16'($urandom), addr: addr, data: data,
              key_down: 1'($urandom), key: 4'($urandom), rnd: 8'($urandom)};
        queue_request(r);
    endtask

    // Build one random instruction, biased toward the defined forms
    function automatic logic [15:0] random_instruction();
        logic [15:0] ins;
        logic [7:0]  misc [10];
        misc = '{c8ie_pkg::MISC_LD_DT, c8ie_pkg::MISC_WAIT, c8ie_pkg::MISC_SET_DT,
                 c8ie_pkg::MISC_SET_ST, c8ie_pkg::MISC_ADD_I, c8ie_pkg::MISC_FONT,
                 c8ie_pkg::MISC_STORE, c8ie_pkg::MISC_LOAD, MISC_BCD, MISC_NONE};
        ins = 16'($urandom);
        case (ins[15:12])
            c8ie_pkg::OPC_SYS:
                if ($urandom_range(0, 3) != 0)
                    ins = $urandom_range(0, 1) ? c8ie_pkg::INS_CLS : c8ie_pkg::INS_RET;
            c8ie_pkg::OPC_LD_I:
                if ($urandom_range(0, 3) != 0)
                    ins[11:0] = 12'h300 + 12'($urandom_range(0, 48));
            c8ie_pkg::OPC_SE_REG, c8ie_pkg::OPC_SNE_REG:
                if ($urandom_range(0, 3) != 0) ins[3:0] = 4'h0;
            c8ie_pkg::OPC_KEY:
                if ($urandom_range(0, 4) != 0)
                    ins[7:0] = $urandom_range(0, 1) ? c8ie_pkg::KEY_SKP : c8ie_pkg::KEY_SKNP;
            c8ie_pkg::OPC_MISC:
                if ($urandom_range(0, 4) != 0) ins[7:0] = misc[$urandom_range(0, 7)];
            default: ;
        endcase
        return ins;
    endfunction

    task automatic queue_random(input int count);
        t_req r;
        int   w;
        for (int k = 0; k < count; k++) begin
            w = $urandom_range(0, 99);
            r = '{op: c8ie_pkg::OP_EXEC, ins: 16'($urandom), addr: 12'($urandom),
                  data: 8'($urandom), key_down: 1'($urandom), key: 4'($urandom),
                  rnd: 8'($urandom)};
            if (w < 14) begin
                r.op = c8ie_pkg::OP_WRITE;
                if ($urandom_range(0, 1)) r.addr = idx_m + 12'($urandom_range(0, 15));
            end else if (w < 22) begin
                r.op = c8ie_pkg::OP_READ_ROW;
            end else if (w < 23) begin
                r.op = OP_UNUSED;
            end else begin
                for (int t = 0; t < 20; t++) begin
                    r.ins = random_instruction();
                    if (r.ins[15:12] == c8ie_pkg::OPC_KEY && $urandom_range(0, 1))
                        r.key = vreg[r.ins[11:8]][3:0];
                    if (reads_defined(r)) break;
                end
                if (!reads_defined(r)) r.ins = {c8ie_pkg::OPC_LD_IMM, 12'($urandom)};
            end
            queue_request(r);
        end
    endtask

    // Hold until every request is sent and answered, then let the block settle
    task automatic drain();
        while (pending_requests.size() != 0 || s_axis_tvalid || expected_snapshots.size() != 0)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_font_base(input logic [11:0] value);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        font_m = value;
    endtask

    // Request driver: pop the next request once the previous one is taken
    always @(posedge i_clk) begin
        t_req r;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= c8ie_pkg::OP_EXEC;
            send_gap      <= 0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (send_gap > 0) begin
                send_gap      <= send_gap - 1;
                s_axis_tvalid <= 1'b0;
            end else if (pending_requests.size() != 0 && !quiet && $urandom_range(0, 9) == 0) begin
                send_gap      <= $urandom_range(0, 9);
                s_axis_tvalid <= 1'b0;
            end else if (pending_requests.size() != 0) begin
                r = pending_requests.pop_front();
                s_axis_tdata  <= {7'd0, r.rnd, r.key, r.key_down, r.data, r.addr, r.ins};
                s_axis_tuser  <= r.op;
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Result monitor: stall at random, compare each result with the oldest snapshot
    always @(posedge i_clk) begin
        t_snap want, got;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            recv_gap      <= 0;
        end else begin
            if (recv_gap > 0) begin
                recv_gap      <= recv_gap - 1;
                m_axis_tready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                recv_gap      <= $urandom_range(0, 9);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = '{pc: m_axis_tdata[11:0], idx: m_axis_tdata[23:12],
                        vf: m_axis_tdata[31:24], dt: m_axis_tdata[39:32],
                        st: m_axis_tdata[47:40], waiting: m_axis_tdata[48],
                        row: m_axis_tdata[112:49]};
                if (expected_snapshots.size() == 0) begin
                    report_mismatch("unexpected result", 64'(got.pc), 64'd0);
                end else begin
                    want = expected_snapshots.pop_front();
                    if (got.pc !== want.pc)
                        report_mismatch("program_counter", 64'(got.pc), 64'(want.pc));
                    if (got.idx !== want.idx)
                        report_mismatch("index_value", 64'(got.idx), 64'(want.idx));
                    if (got.vf !== want.vf)
                        report_mismatch("flag_value", 64'(got.vf), 64'(want.vf));
                    if (got.dt !== want.dt)
                        report_mismatch("delay_value", 64'(got.dt), 64'(want.dt));
                    if (got.st !== want.st)
                        report_mismatch("sound_value", 64'(got.st), 64'(want.st));
                    if (got.waiting !== want.waiting)
                        report_mismatch("waiting_key", 64'(got.waiting), 64'(want.waiting));
                    if (got.row !== want.row) report_mismatch("screen_row", got.row, want.row);
                end
            end
        end
    end

    initial begin
        mismatches    = 0;
        quiet         = 0;
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        for (int i = 0; i < 16; i++) begin
            vreg[i] = 0; call_stack[i] = 0; call_ok[i] = 0;
        end
        for (int i = 0; i < 4096; i++) begin
            ram[i] = 0; ram_ok[i] = 0;
        end
        for (int i = 0; i < 32; i++) frame[i] = '0;
        pc_m = 12'h200; idx_m = 0; sp_m = 0; dt_m = 0; st_m = 0; font_m = 0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Font base at its top so that Fx29 wraps
        write_font_base(12'hFFF);

        // Sprite bytes straddling the top of RAM, drawn at the bottom-right corner
        queue_write(12'hFFF, 8'hF0);
        queue_write(12'h000, 8'h81);
        queue_exec(16'h6A3F, 0, 0);
        queue_exec(16'h6B1F, 0, 0);
        queue_exec(16'hAFFF, 0, 0);
        queue_exec(16'hDAB2, 0, 0);
        queue_exec(16'hDAB2, 0, 0);   // second pass collides
        queue_exec(16'hDAB1, 0, 0);
        queue_exec(16'hDAB0, 0, 0);   // zero rows draws nothing
        queue_request('{op: c8ie_pkg::OP_READ_ROW, ins: 16'hFFFF, addr: 12'hFFF,
                        data: 8'hFF, key_down: 1, key: 4'hF, rnd: 8'hFF});
        queue_exec(16'h00E0, 1, 4'hF);
        queue_exec(16'h2FFE, 0, 0);
        queue_exec(16'h00EE, 0, 0);
        queue_exec(16'h1FFF, 0, 0);
        queue_exec(16'h3A3F, 0, 0);
        queue_exec(16'h4A3F, 0, 0);
        queue_exec(16'h5AA0, 0, 0);
        queue_exec(16'h5AA1, 0, 0);   // unassigned low nibble
        queue_exec(16'h9AB0, 0, 0);
        queue_exec(16'h7AFF, 0, 0);   // wraps past 255
        queue_exec(16'h8AB4, 0, 0);
        queue_exec(16'h8AB5, 0, 0);
        queue_exec(16'h8AB6, 0, 0);
        queue_exec(16'h8AB7, 0, 0);
        queue_exec(16'h8ABE, 0, 0);
        queue_exec(16'h8AB8, 0, 0);
        queue_exec(16'h8FA4, 0, 0);   // carry lands in VF, then the sum wins
        queue_exec(16'h60FF, 0, 0);
        queue_exec(16'hBFFF, 0, 0);
        queue_exec(16'hCAFF, 0, 0);
        queue_exec(16'hEA9E, 1, vreg[4'hA][3:0]);
        queue_exec(16'hEAA1, 0, 0);
        queue_exec(16'hFA0A, 0, 0);   // no key: PC held
        queue_exec(16'hFA0A, 1, 4'h5);
        queue_exec(16'hF515, 0, 0);
        queue_exec(16'hF518, 0, 0);
        queue_exec(16'hFA07, 0, 0);
        queue_exec(16'hFA29, 0, 0);
        queue_exec(16'hA300, 0, 0);
        queue_exec(16'hFF55, 0, 0);
        queue_exec(16'hA300, 0, 0);
        queue_exec(16'hFF65, 0, 0);
        queue_exec(16'hF533, 0, 0);
        queue_request('{op: OP_UNUSED, ins: 16'h0, addr: 12'h0, data: 8'h0,
                        key_down: 0, key: 4'h0, rnd: 8'h0});
        drain();

        // Seed a sprite area so random draws and loads have defined bytes
        write_font_base(12'h000);
        for (int a = 12'h300; a < 12'h340; a++) queue_write(a[11:0], 8'($urandom));
        queue_random(180);
        drain();

        write_font_base(12'($urandom));
        queue_random(180);
        drain();

        // Final stretch runs at full rate on both sides
        write_font_base(12'h5A5);
        quiet = 1;
        queue_random(180);
        drain();

        if (mismatches == 0 && expected_snapshots.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

[filelist.f]
design/c8ie_pkg.sv
design/c8ie_ctrl.sv
design/c8ie_datapath.sv
design/chip8_instruction_execute.sv
dv/chip8_instruction_execute_tb.sv
